@@ src/assert_macros.svh @@
// Assertion macros shared by the summed-area RTL.
// Defining NO_ASSERTIONS compiles every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked at every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("assertion failed");

// Condition that must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

@@ src/iimt_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, types and helpers for the three-moment summed-area unit.
// No dependencies; every other file except assert_macros.svh imports this package.
package iimt_pkg;

	// Image limits
	localparam int MAX_COLS = 2048;
	localparam int MAX_ROWS = 2048;
	localparam int COL_W    = $clog2(MAX_COLS);
	localparam int ROW_W    = $clog2(MAX_ROWS);
	localparam int SIZE_W   = 12;

	// Pixel and power widths
	localparam int PIXEL_W = 8;
	localparam int SQ_W    = 2 * PIXEL_W;
	localparam int CUBE_W  = 3 * PIXEL_W;

	// Row run sums
	localparam int RUN1_W = 20;
	localparam int RUN2_W = 27;
	localparam int RUN3_W = 35;

	// Line store / accumulated area sums
	localparam int ACC1_W = 31;
	localparam int ACC2_W = 38;
	localparam int ACC3_W = 47;

	// Result fields
	localparam int OUT1_W = 30;
	localparam int OUT2_W = 38;
	localparam int OUT3_W = 46;

	// Configuration port
	localparam int APB_AW    = 3;
	localparam int APB_DW    = 32;
	localparam int REG_IDX_W = APB_AW - 2;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Clamped frame size seen by the front
	typedef struct packed {
		logic [SIZE_W-1:0] width;
		logic [SIZE_W-1:0] height;
	} frame_size_t;

	// One classified pixel, front to back
	typedef struct packed {
		logic [PIXEL_W-1:0] pixel;
		logic [COL_W-1:0]   col;
		logic               first_col;
		logic               use_above;
		logic               frame_last;
	} job_t;

	// One line store entry: the three area sums of a pixel
	typedef struct packed {
		logic [ACC3_W-1:0] cube;
		logic [ACC2_W-1:0] sq;
		logic [ACC1_W-1:0] sum;
	} moments_t;

	// Zero acts as one, anything above the limit acts as the limit
	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
	                                                 input logic [SIZE_W-1:0] lim);
		logic [SIZE_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = SIZE_W'(1);
		end else if (v > lim) begin
			r = lim;
		end
		return r;
	endfunction

endpackage

@@ src/iimt_channels.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces: pixel beats in, moment beats out.
// Depends on iimt_pkg for field widths.
interface iimt_pixel_if;
	import iimt_pkg::*;

	logic               valid;
	logic               ready;
	logic [PIXEL_W-1:0] pixel;

	modport source (output valid, output pixel, input ready);
	modport sink   (input valid, input pixel, output ready);
endinterface

interface iimt_moment_if;
	import iimt_pkg::*;

	logic              valid;
	logic              ready;
	logic [OUT1_W-1:0] area_sum;
	logic [OUT2_W-1:0] area_sum_sq;
	logic [OUT3_W-1:0] area_sum_cube;
	logic              frame_last;

	modport source (output valid, output area_sum, output area_sum_sq,
	                output area_sum_cube, output frame_last, input ready);
	modport sink   (input valid, input area_sum, input area_sum_sq,
	                input area_sum_cube, input frame_last, output ready);
endinterface

@@ src/iimt_front.sv @@
`timescale 1ns / 1ps
// Front end: takes pixel beats, tracks column and row, tags each pixel.
// Depends on iimt_pkg and iimt_channels.
`include "assert_macros.svh"
module iimt_front (
	input  logic                 clk,
	input  logic                 arst_n,
	iimt_pixel_if.sink           pixels,
	input  iimt_pkg::frame_size_t size,
	input  logic                 job_ready,
	output logic                 job_valid,
	output iimt_pkg::job_t       job
);
	import iimt_pkg::*;

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic              accept;
	logic [SIZE_W-1:0] col_inc;
	logic [SIZE_W-1:0] row_inc;
	logic              col_wrap;
	logic              row_wrap;

	// Handshake straight through to the queue
	assign pixels.ready = job_ready;
	assign job_valid    = pixels.valid;
	assign accept       = pixels.valid && job_ready;

	// Position arithmetic
	assign col_inc  = SIZE_W'(col_q) + SIZE_W'(1);
	assign row_inc  = SIZE_W'(row_q) + SIZE_W'(1);
	assign col_wrap = col_inc >= size.width;
	assign row_wrap = row_inc >= size.height;

	// Classify the pixel
	always_comb begin
		job.pixel      = pixels.pixel;
		job.col        = col_q;
		job.first_col  = (col_q == '0);
		job.use_above  = (row_q != '0);
		job.frame_last = (SIZE_W'(col_q) == size.width - SIZE_W'(1)) &&
		                 (SIZE_W'(row_q) == size.height - SIZE_W'(1));
	end

	// Counters wrap at the configured size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : ROW_W'(row_inc);
			end else begin
				col_q <= COL_W'(col_inc);
			end
		end
	end

	`ASSERT_CLK(a_frame_end_rewinds, clk, arst_n, (accept && job.frame_last) |=> (col_q == '0 && row_q == '0))
	`ASSERT_CLK(a_idle_holds_pos, clk, arst_n, !accept |=> ($stable(col_q) && $stable(row_q)))
	`ASSERT_CLK(a_row_holds_midline, clk, arst_n, (accept && !col_wrap) |=> (row_q == $past(row_q)))

endmodule

@@ src/iimt_queue.sv @@
`timescale 1ns / 1ps
// Small job queue that decouples the front end from the back end.
// Depends on iimt_pkg.
`include "assert_macros.svh"
module iimt_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  iimt_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output iimt_pkg::job_t head,
	output logic           empty
);
	import iimt_pkg::*;

	job_t              ent_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = ent_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_job;
		end
	end

	`ASSERT_NEVER(a_no_overflow, clk, arst_n, push && full)
	`ASSERT_NEVER(a_no_underflow, clk, arst_n, pop && empty)
	`ASSERT_CLK(a_count_tracks_ptrs, clk, arst_n, (push && !pop) |=> (cnt_q == $past(cnt_q) + QCNT_W'(1)))

endmodule

@@ src/iimt_back.sv @@
`timescale 1ns / 1ps
// Back end: powers, row run sums, line store and forwarding, result register.
// Depends on iimt_pkg and iimt_channels.
`include "assert_macros.svh"
module iimt_back (
	input  logic           clk,
	input  logic           arst_n,
	input  iimt_pkg::job_t job,
	input  logic           job_valid,
	output logic           job_pop,
	iimt_moment_if.source  moments
);
	import iimt_pkg::*;

	// Line store of the previous row's area sums
	moments_t line_mem [MAX_COLS];

	logic              adv;
	logic              v_s2;
	logic              v_s3;
	logic              v_s4;
	logic              out_valid_q;

	job_t              job_s2;
	job_t              job_s3;
	job_t              job_s4;
	logic [SQ_W-1:0]   sq_s2;
	logic [SQ_W-1:0]   sq_s3;
	logic [CUBE_W-1:0] cube_s3;
	moments_t          mem_rd_s2;
	moments_t          mem_rd_s3;
	moments_t          above_s4;
	moments_t          fwd;
	moments_t          sum_s4;

	logic [RUN1_W-1:0] run1_q;
	logic [RUN2_W-1:0] run2_q;
	logic [RUN3_W-1:0] run3_q;

	// Last two line store writes, newest in wr1
	logic              wr1_v_q;
	logic              wr2_v_q;
	logic [COL_W-1:0]  wr1_col_q;
	logic [COL_W-1:0]  wr2_col_q;
	moments_t          wr1_data_q;
	moments_t          wr2_data_q;

	moments_t          out_q;
	logic              out_last_q;

	// Whole pipeline moves when the result register can take a beat
	assign adv     = !out_valid_q || moments.ready;
	assign job_pop = adv && job_valid;

	// Above value: newest pending or recent write wins over the stale read
	always_comb begin
		if (v_s4 && job_s4.col == job_s3.col) begin
			fwd = sum_s4;
		end else if (wr1_v_q && wr1_col_q == job_s3.col) begin
			fwd = wr1_data_q;
		end else if (wr2_v_q && wr2_col_q == job_s3.col) begin
			fwd = wr2_data_q;
		end else begin
			fwd = mem_rd_s3;
		end
	end

	// Area sums: row run plus the row above
	always_comb begin
		sum_s4.sum  = ACC1_W'(run1_q) + above_s4.sum;
		sum_s4.sq   = ACC2_W'(run2_q) + above_s4.sq;
		sum_s4.cube = ACC3_W'(run3_q) + above_s4.cube;
	end

	// Stage valids and write history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
			wr1_v_q     <= 1'b0;
			wr2_v_q     <= 1'b0;
		end else if (adv) begin
			v_s2        <= job_valid;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			out_valid_q <= v_s4;
			if (v_s4) begin
				wr1_v_q <= 1'b1;
				wr2_v_q <= wr1_v_q;
			end
		end
	end

	// Stage payloads
	always_ff @(posedge clk) begin
		if (adv) begin
			// S2: square and line store read
			job_s2    <= job;
			sq_s2     <= SQ_W'(job.pixel) * SQ_W'(job.pixel);
			mem_rd_s2 <= line_mem[job.col];

			// S3: cube
			job_s3    <= job_s2;
			sq_s3     <= sq_s2;
			cube_s3   <= CUBE_W'(sq_s2) * CUBE_W'(job_s2.pixel);
			mem_rd_s3 <= mem_rd_s2;

			// S4: row run sums and resolved above value
			job_s4 <= job_s3;
			if (v_s3) begin
				run1_q <= (job_s3.first_col ? '0 : run1_q) + RUN1_W'(job_s3.pixel);
				run2_q <= (job_s3.first_col ? '0 : run2_q) + RUN2_W'(sq_s3);
				run3_q <= (job_s3.first_col ? '0 : run3_q) + RUN3_W'(cube_s3);
			end
			above_s4 <= job_s3.use_above ? fwd : '0;

			// Result register and write history
			if (v_s4) begin
				out_q      <= sum_s4;
				out_last_q <= job_s4.frame_last;
				wr1_col_q  <= job_s4.col;
				wr1_data_q <= sum_s4;
				wr2_col_q  <= wr1_col_q;
				wr2_data_q <= wr1_data_q;
			end
		end
	end

	// Line store write
	always_ff @(posedge clk) begin
		if (adv && v_s4) begin
			line_mem[job_s4.col] <= sum_s4;
		end
	end

	assign moments.valid         = out_valid_q;
	assign moments.area_sum      = out_q.sum[OUT1_W-1:0];
	assign moments.area_sum_sq   = out_q.sq[OUT2_W-1:0];
	assign moments.area_sum_cube = out_q.cube[OUT3_W-1:0];
	assign moments.frame_last    = out_last_q;

	`ASSERT_CLK(a_write_logged, clk, arst_n, (adv && v_s4) |=> (wr1_v_q && wr1_col_q == $past(job_s4.col)))
	`ASSERT_CLK(a_result_loaded, clk, arst_n, (adv && v_s4) |=> out_valid_q)
	`ASSERT_CLK(a_stall_freezes, clk, arst_n, !adv |=> ($stable(v_s2) && $stable(v_s3) && $stable(v_s4)))

endmodule

@@ src/integral_image_three_moments_unit.sv @@
`timescale 1ns / 1ps
// Top level: config registers, front end, job queue and back end.
// Depends on iimt_pkg, iimt_channels, iimt_front, iimt_queue, iimt_back.
//
//  channel   dir  beat fields
//  pixels    in   pixel[7:0]
//  moments   out  area_sum[29:0], area_sum_sq[37:0], area_sum_cube[45:0], frame_last
//  apb       cfg  0x0 image_width, 0x4 image_height (12 bits each)
//
// Sustains one pixel per cycle while results are taken; each accepted pixel passes
// through the queue, then the square, cube, run-sum and area-add stages of the back end.
// Reset clears counters, queue and stage valids; sizes return to 2048 x 2048.
// The line store needs no clearing pass: the first row of a frame never uses what it reads.
// A stalled result freezes the back end; the 4-entry queue keeps accepting until full.
module integral_image_three_moments_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	iimt_pixel_if.sink                  pixels,
	iimt_moment_if.source               moments,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [iimt_pkg::APB_AW-1:0] paddr,
	input  logic [iimt_pkg::APB_DW-1:0] pwdata,
	output logic [iimt_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);
	import iimt_pkg::*;

	logic [SIZE_W-1:0]    width_q;
	logic [SIZE_W-1:0]    height_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 cfg_wr;
	frame_size_t          size;

	job_t                 push_job;
	job_t                 head;
	logic                 push_valid;
	logic                 full;
	logic                 empty;
	logic                 pop;

	// Register access
	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_AW-1:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_W'(MAX_COLS);
			height_q <= SIZE_W'(MAX_ROWS);
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_IMAGE_WIDTH:  width_q  <= pwdata[SIZE_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= pwdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_IMAGE_WIDTH:  prdata = APB_DW'(width_q);
			REG_IMAGE_HEIGHT: prdata = APB_DW'(height_q);
			default:          prdata = '0;
		endcase
	end

	// Effective frame size
	assign size.width  = clamp_size(width_q, SIZE_W'(MAX_COLS));
	assign size.height = clamp_size(height_q, SIZE_W'(MAX_ROWS));

	iimt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixels    (pixels),
		.size      (size),
		.job_ready (!full),
		.job_valid (push_valid),
		.job       (push_job)
	);

	iimt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push_valid && !full),
		.push_job (push_job),
		.full     (full),
		.pop      (pop),
		.head     (head),
		.empty    (empty)
	);

	iimt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (head),
		.job_valid (!empty),
		.job_pop   (pop),
		.moments   (moments)
	);

endmodule
